// ===== rtl/vsaa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsaa_pkg
// Shared types, constants and the area lookup for the voxel surface area
// accumulator.
// ----------------------------------------------------------------------------
package vsaa_pkg;

  // defaults for the top-level parameters
  localparam int MAX_OBJECTS_DEF = 16;
  localparam int LABEL_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int ACC_BITS_DEF    = 48;

  // fixed field widths
  localparam int LABEL_IN_W = 16;
  localparam int NB_COUNT   = 6;
  localparam int OUT_AREA_W = 48;

  // operation codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_VOXEL = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // per-slot lane control, one beat of the match stage
  typedef struct packed {
    logic       hit;
    logic       clr;
    logic [5:0] mask;
  } lane_ctl_t;

  // neighbourhood configuration class for each same-label mask
  localparam logic [3:0] CONFIG_CLASS [64] = '{
    4'd0, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd2, 4'd4,
    4'd1, 4'd3, 4'd2, 4'd5, 4'd2, 4'd5, 4'd4, 4'd6,
    4'd1, 4'd2, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd6,
    4'd2, 4'd5, 4'd5, 4'd7, 4'd4, 4'd6, 4'd6, 4'd8,
    4'd1, 4'd2, 4'd2, 4'd4, 4'd3, 4'd5, 4'd5, 4'd6,
    4'd2, 4'd5, 4'd4, 4'd6, 4'd5, 4'd7, 4'd6, 4'd8,
    4'd2, 4'd4, 4'd5, 4'd6, 4'd5, 4'd6, 4'd7, 4'd8,
    4'd4, 4'd6, 4'd6, 4'd8, 4'd6, 4'd8, 4'd8, 4'd9
  };

  // area of each class, 32 fraction bits
  localparam logic [33:0] CLASS_AREA_Q32 [10] = '{
    34'd6746518852,
    34'd1919751452,
    34'd2879482230,
    34'd5726623061,
    34'd3410032767,
    34'd1919751452,
    34'd2879482230,
    34'd4294967296,
    34'd1919751452,
    34'd0
  };

  // area of a mask, rounded to frac fraction bits
  function automatic logic [33:0] class_area(input logic [5:0] mask, input int frac);
    logic [34:0] rnd;
    rnd = {1'b0, CLASS_AREA_Q32[CONFIG_CLASS[mask]]} + (35'd1 << (31 - frac));
    return 34'(rnd >> (32 - frac));
  endfunction

endpackage

// ===== rtl/vsaa_match.sv =====
// ----------------------------------------------------------------------------
// vsaa_match
// Object label table and label compare stage. Every slot compares its label
// against the centre and the six neighbours and builds its lane control.
// ----------------------------------------------------------------------------
module vsaa_match #(
  parameter int MAX_OBJECTS = vsaa_pkg::MAX_OBJECTS_DEF,
  parameter int LABEL_BITS  = vsaa_pkg::LABEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                fire_i,
  input  logic [1:0]                          operation_i,
  input  logic [3:0]                          slot_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]     object_id_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]     center_label_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]     nb_label_i [vsaa_pkg::NB_COUNT],
  input  logic [vsaa_pkg::NB_COUNT-1:0]       inside_mask_i,
  output vsaa_pkg::lane_ctl_t                 ctl_o [MAX_OBJECTS]
);
  import vsaa_pkg::*;

  localparam int LBL_W = (LABEL_BITS < LABEL_IN_W) ? LABEL_BITS : LABEL_IN_W;

  logic [LBL_W-1:0]    table_q [MAX_OBJECTS];
  lane_ctl_t           ctl_q   [MAX_OBJECTS];
  lane_ctl_t           ctl_d   [MAX_OBJECTS];
  logic [LBL_W-1:0]    c_lbl;
  logic [LBL_W-1:0]    nb     [NB_COUNT];
  logic                c_first [MAX_OBJECTS];
  logic                c_found;
  logic                c_eq;
  logic [NB_COUNT-1:0] c_mask;
  logic [NB_COUNT-1:0] n_found;
  logic                n_eq;
  logic [NB_COUNT-1:0] sel    [MAX_OBJECTS];
  logic                is_voxel;
  logic                is_load;
  logic [MAX_OBJECTS-1:0] hit_vec;

  assign is_voxel = fire_i && (operation_i == OP_VOXEL);
  assign is_load  = fire_i && (operation_i == OP_LOAD);

  // label compares and lowest-slot priority per label
  always_comb begin
    c_lbl   = center_label_i[LBL_W-1:0];
    c_found = 1'b0;
    n_found = '0;
    for (int i = 0; i < NB_COUNT; i++) begin
      nb[i]     = nb_label_i[i][LBL_W-1:0];
      c_mask[i] = inside_mask_i[i] && (nb[i] == c_lbl);
    end
    for (int s = 0; s < MAX_OBJECTS; s++) begin
      c_eq       = (c_lbl != '0) && (table_q[s] == c_lbl);
      c_first[s] = c_eq && !c_found;
      c_found    = c_found || c_eq;
      for (int i = 0; i < NB_COUNT; i++) begin
        n_eq       = inside_mask_i[i] && (nb[i] != '0) && (table_q[s] == nb[i]);
        sel[s][i]  = n_eq && !n_found[i];
        n_found[i] = n_found[i] || n_eq;
      end
    end
    // centre listed: its own slot only; otherwise each neighbour group
    for (int s = 0; s < MAX_OBJECTS; s++) begin
      ctl_d[s].clr = is_load && (32'(slot_i) == s);
      if (c_found) begin
        ctl_d[s].hit  = is_voxel && c_first[s];
        ctl_d[s].mask = c_mask;
      end else begin
        ctl_d[s].hit  = is_voxel && (sel[s] != '0);
        ctl_d[s].mask = ~sel[s];
      end
    end
  end

  // label table and lane control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAX_OBJECTS; s++) begin
        table_q[s] <= '0;
        ctl_q[s]   <= '0;
      end
    end else begin
      for (int s = 0; s < MAX_OBJECTS; s++) begin
        if (is_load && (32'(slot_i) == s)) begin
          table_q[s] <= object_id_i[LBL_W-1:0];
        end
        if (adv_i) begin
          ctl_q[s] <= ctl_d[s];
        end
      end
    end
  end

  assign ctl_o = ctl_q;

  always_comb begin
    for (int s = 0; s < MAX_OBJECTS; s++) begin
      hit_vec[s] = ctl_q[s].hit;
    end
  end

  // one voxel touches at most one slot per neighbour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(hit_vec) <= NB_COUNT)
    else $error("more slots hit than neighbours");

  // a load and a voxel never share a beat
  for (genvar s = 0; s < MAX_OBJECTS; s++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      !(ctl_q[s].hit && ctl_q[s].clr))
      else $error("slot both cleared and hit");
  end

endmodule

// ===== rtl/vsaa_lane.sv =====
// ----------------------------------------------------------------------------
// vsaa_lane
// One object slot: area lookup for its mask, then a saturating accumulator
// with its saturation flag.
// ----------------------------------------------------------------------------
module vsaa_lane #(
  parameter int FRAC_BITS = vsaa_pkg::FRAC_BITS_DEF,
  parameter int ACC_BITS  = vsaa_pkg::ACC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  vsaa_pkg::lane_ctl_t ctl_i,
  output logic [ACC_BITS-1:0] acc_o,
  output logic                sat_o
);
  import vsaa_pkg::*;

  localparam int AREA_W = FRAC_BITS + 2;
  localparam int SUM_W  = ((ACC_BITS > AREA_W) ? ACC_BITS : AREA_W) + 1;

  logic [33:0]         area_full;
  logic [AREA_W-1:0]   area_q;
  logic                hit_q;
  logic                clr_q;
  logic [ACC_BITS-1:0] acc_q;
  logic                sat_q;
  logic [SUM_W-1:0]    sum;
  logic                ovf;

  assign area_full = class_area(ctl_i.mask, FRAC_BITS);

  // area lookup register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      area_q <= area_full[AREA_W-1:0];
    end
  end

  assign sum = SUM_W'(acc_q) + SUM_W'(area_q);
  assign ovf = (sum[SUM_W-1:ACC_BITS] != '0);

  // control and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      clr_q <= 1'b0;
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (adv_i) begin
      hit_q <= ctl_i.hit;
      clr_q <= ctl_i.clr;
      if (clr_q) begin
        acc_q <= '0;
        sat_q <= 1'b0;
      end else if (hit_q) begin
        if (ovf) begin
          acc_q <= '1;
          sat_q <= 1'b1;
        end else begin
          acc_q <= sum[ACC_BITS-1:0];
        end
      end
    end
  end

  assign acc_o = acc_q;
  assign sat_o = sat_q;

  // flag only ever set together with a full accumulator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (&acc_q))
    else $error("saturation flag without full accumulator");

  // a load clears the slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && clr_q |=> (acc_q == '0) && !sat_q)
    else $error("slot not cleared by load");

endmodule

// ===== rtl/voxel_surface_area_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_surface_area_accumulator_unit
// Read path: a read result passes through s1, s2 and the output register.
// Throughput: one item per clock; input stalls only while a read sits at the
// last stage and the output register holds an untaken result.
// Reset clears the label table, all accumulators and flags.
// Lanes: one compare lane and one accumulator lane per object slot.
// ----------------------------------------------------------------------------
module voxel_surface_area_accumulator_unit #(
  parameter int MAX_OBJECTS = vsaa_pkg::MAX_OBJECTS_DEF,
  parameter int LABEL_BITS  = vsaa_pkg::LABEL_BITS_DEF,
  parameter int FRAC_BITS   = vsaa_pkg::FRAC_BITS_DEF,
  parameter int ACC_BITS    = vsaa_pkg::ACC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         operation_i,
  input  logic [3:0]                         slot_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]    object_id_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]    center_label_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]    label_x_plus_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]    label_y_plus_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]    label_z_plus_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]    label_x_minus_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]    label_y_minus_i,
  input  logic [vsaa_pkg::LABEL_IN_W-1:0]    label_z_minus_i,
  input  logic [vsaa_pkg::NB_COUNT-1:0]      inside_mask_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [vsaa_pkg::OUT_AREA_W-1:0]    area_total_o,
  output logic [3:0]                         read_slot_o,
  output logic                               saturated_o
);
  import vsaa_pkg::*;

  logic [LABEL_IN_W-1:0] nb_label [NB_COUNT];
  lane_ctl_t             ctl      [MAX_OBJECTS];
  logic [ACC_BITS-1:0]   acc      [MAX_OBJECTS];
  logic                  sat      [MAX_OBJECTS];

  logic                  adv;
  logic                  fire;
  logic                  s1_read_q;
  logic [3:0]            s1_slot_q;
  logic                  s2_read_q;
  logic [3:0]            s2_slot_q;
  logic [ACC_BITS-1:0]   rd_acc;
  logic                  rd_sat;
  logic [ACC_BITS+OUT_AREA_W-1:0] rd_wide;
  logic                  out_valid_q;
  logic [OUT_AREA_W-1:0] area_total_q;
  logic [3:0]            read_slot_q;
  logic                  saturated_q;

  // pipeline holds only when a read cannot move into the output register
  assign adv        = !(s2_read_q && out_valid_q && !out_ready_i);
  assign in_ready_o = adv;
  assign fire       = in_valid_i && adv;

  assign nb_label[0] = label_x_plus_i;
  assign nb_label[1] = label_y_plus_i;
  assign nb_label[2] = label_z_plus_i;
  assign nb_label[3] = label_x_minus_i;
  assign nb_label[4] = label_y_minus_i;
  assign nb_label[5] = label_z_minus_i;

  // label compare lanes
  vsaa_match #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .LABEL_BITS  (LABEL_BITS)
  ) u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .fire_i         (fire),
    .operation_i    (operation_i),
    .slot_i         (slot_i),
    .object_id_i    (object_id_i),
    .center_label_i (center_label_i),
    .nb_label_i     (nb_label),
    .inside_mask_i  (inside_mask_i),
    .ctl_o          (ctl)
  );

  // accumulator lanes, one per slot
  for (genvar s = 0; s < MAX_OBJECTS; s++) begin : g_lane
    vsaa_lane #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_BITS  (ACC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ctl[s]),
      .acc_o  (acc[s]),
      .sat_o  (sat[s])
    );
  end

  // read slot select across the lanes
  always_comb begin
    rd_acc = '0;
    rd_sat = 1'b0;
    for (int s = 0; s < MAX_OBJECTS; s++) begin
      if (32'(s2_slot_q) == s) begin
        rd_acc = acc[s];
        rd_sat = sat[s];
      end
    end
  end

  assign rd_wide = {{OUT_AREA_W{1'b0}}, rd_acc};

  // read tracking through the lane stages and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_read_q   <= 1'b0;
      s2_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_read_q <= fire && (operation_i == OP_READ);
        s2_read_q <= s1_read_q;
      end
      if (adv && s2_read_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // read payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_slot_q <= slot_i;
      s2_slot_q <= s1_slot_q;
    end
    if (adv && s2_read_q) begin
      area_total_q <= rd_wide[OUT_AREA_W-1:0];
      read_slot_q  <= s2_slot_q;
      saturated_q  <= rd_sat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign area_total_o = area_total_q;
  assign read_slot_o  = read_slot_q;
  assign saturated_o  = saturated_q;

  // a read leaving the last stage becomes the output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s2_read_q |=> out_valid_o && (read_slot_o == $past(s2_slot_q)))
    else $error("read beat lost at output");

  // no new beat accepted while a read is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_read_q && out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while read is blocked");

endmodule
